FILE: rtl/core/ihse_pkg.sv
// Package for the infinite hexahedron shape evaluator.
// Holds the word types, fixed-point constants and rounding helpers.
// No dependencies.
package ihse_pkg;

  localparam int FB = 14;          // input fraction bits
  localparam int OB = 16;          // output fraction bits
  localparam int NODE_W = 3;
  localparam logic [NODE_W-1:0] LAST_NODE = 3'd7;

  localparam int CRD_W = 18;       // working width of coordinate terms
  localparam int SQ_W  = 36;       // products of two coordinate terms
  localparam int DER_W = 54;       // coordinate term times square term
  localparam int MAG_W = 72;       // square term times square term
  localparam int NUM_W = 48;       // divider dividend
  localparam int DEN_W = 33;       // divider divisor

  localparam logic signed [CRD_W-1:0] ONE_Q  = CRD_W'(64'd1 << FB);
  localparam logic signed [SQ_W-1:0]  ONE_SQ = SQ_W'(64'd1 << (2 * FB));

  // rounding shifts for upper (zeta^2-zeta)/2 and lower (1-zeta^2) nodes
  localparam int SH_VAL_U = 4 * FB + 3 - OB;
  localparam int SH_VAL_L = 4 * FB + 2 - OB;
  localparam int SH_DER_U = 3 * FB + 3 - OB;
  localparam int SH_DER_L = 3 * FB + 2 - OB;
  localparam int SH_DZ_U  = 3 * FB + 3 - OB;
  localparam int SH_DZ_L  = 3 * FB + 1 - OB;

  typedef struct packed {
    logic signed [15:0] coord_xi;
    logic signed [15:0] coord_eta;
    logic signed [15:0] coord_zeta;
  } in_word_t;

  typedef struct packed {
    logic [NODE_W-1:0]  node_index;
    logic signed [31:0] shape_value;
    logic signed [31:0] shape_d_xi;
    logic signed [31:0] shape_d_eta;
    logic signed [31:0] shape_d_zeta;
    logic signed [31:0] map_d_xi;
    logic signed [31:0] map_d_eta;
    logic signed [31:0] map_d_zeta;
    logic               pole_flag;
    logic               last_node;
  } out_word_t;

  // shape results waiting for the divider pipeline
  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [31:0]       val;
    logic [31:0]       dxi;
    logic [31:0]       deta;
    logic [31:0]       dzeta;
    logic              pole;
    logic              last;
    logic              neg_xi;
    logic              neg_eta;
    logic              neg_zeta;
  } mid_t;

  // round to nearest, ties away from zero, on a magnitude
  function automatic logic [63:0] rnd_shift(input logic [MAG_W-1:0] m, input int sh);
    logic [MAG_W-1:0] t;
    t = m >> sh;
    return 64'(t) + 64'(m[sh-1]);
  endfunction

  // apply sign and clamp to the 32-bit signed range
  function automatic logic [31:0] sat32(input logic [63:0] mag, input logic neg);
    logic [31:0] r;
    if (mag > 64'h8000_0000) begin
      r = neg ? 32'h8000_0000 : 32'h7fff_ffff;
    end else if (neg) begin
      r = ~mag[31:0] + 32'd1;
    end else if (mag[31]) begin
      r = 32'h7fff_ffff;
    end else begin
      r = mag[31:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/ihse_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Gives the quotient and a round-up bit (twice the remainder at least the divisor).
// No dependencies.
module ihse_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 33
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quot,
  output logic             round_up
);

  // n holds the unused dividend bits on top and the quotient bits below
  logic [NUM_W-1:0] n [NUM_W];
  logic [DEN_W-1:0] r [NUM_W];
  logic [DEN_W-1:0] d [NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic [NUM_W-1:0] n_src;
    logic [DEN_W-1:0] r_src;
    logic [DEN_W-1:0] d_src;
    logic [DEN_W:0]   part;
    logic             ge;

    if (i == 0) begin : g_first
      assign n_src = num;
      assign r_src = '0;
      assign d_src = den;
    end else begin : g_next
      assign n_src = n[i-1];
      assign r_src = r[i-1];
      assign d_src = d[i-1];
    end

    always_comb begin
      part = {r_src, n_src[NUM_W-1]};
      ge   = (part >= {1'b0, d_src});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r[i] <= ge ? DEN_W'(part - {1'b0, d_src}) : DEN_W'(part);
        n[i] <= {n_src[NUM_W-2:0], ge};
        d[i] <= d_src;
      end
    end
  end

  assign quot     = n[NUM_W-1];
  assign round_up = ({r[NUM_W-1], 1'b0} >= {1'b0, d[NUM_W-1]});

endmodule

FILE: rtl/core/infinite_hex_shape_eval.sv
// Infinite hexahedron shape evaluator, top level.
// Uses ihse_pkg and ihse_div.
//
// Input channel: in_valid / in_stall carry one word with xi, eta, zeta (Q1.14).
// Output channel: out_valid / out_stall carry one result word per node,
// nodes 0 to 7 in order, last_node set on node 7. Values are Q15.16, saturated.
// When zeta is exactly one, pole_flag is set and the mapping terms are zero.
// Each input word expands into eight nodes, one node per cycle unless out_stall
// holds the pipeline; the next word is accepted in the cycle the last node of
// the current one issues. The result path holds five arithmetic stages, 48
// stages of the one-bit-per-stage divider for the mapping terms, and the
// output register.
// out_stall freezes the whole pipeline while out_valid is high; nothing is
// dropped or repeated, and in_stall rises once the node issue register is full.
// Reset (rst, synchronous) empties the pipeline; no other state exists.
module infinite_hex_shape_eval (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  ihse_pkg::in_word_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ihse_pkg::out_word_t out_data
);

  localparam int CW = ihse_pkg::CRD_W;
  localparam int SW = ihse_pkg::SQ_W;
  localparam int DW = ihse_pkg::DER_W;
  localparam int MW = ihse_pkg::MAG_W;
  localparam int NW = ihse_pkg::NUM_W;
  localparam int EW = ihse_pkg::DEN_W;
  localparam int KW = ihse_pkg::NODE_W;

  logic adv, accept, issue;
  logic hold_valid;
  logic [KW-1:0] cnt;
  ihse_pkg::in_word_t hold;

  assign adv      = !out_valid || !out_stall;
  assign issue    = hold_valid && adv;
  assign in_stall = hold_valid && !(adv && cnt == ihse_pkg::LAST_NODE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      cnt        <= '0;
    end else begin
      if (issue) cnt <= cnt + KW'(1);
      if (issue && cnt == ihse_pkg::LAST_NODE) hold_valid <= 1'b0;
      if (accept) begin
        hold_valid <= 1'b1;
        cnt        <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) hold <= in_data;
  end

  // stage 1: node factors
  logic v1, up1, xn1, yn1, pole1, last1;
  logic [KW-1:0] k1;
  logic signed [CW-1:0] xf1, yf1, z1, zm1;
  logic signed [CW-1:0] xe, ye, ze;
  logic xneg, yneg;

  assign xe   = CW'(hold.coord_xi);
  assign ye   = CW'(hold.coord_eta);
  assign ze   = CW'(hold.coord_zeta);
  assign xneg = (cnt[0] == cnt[1]);
  assign yneg = ~cnt[1];

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= issue;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k1    <= cnt;
      up1   <= ~cnt[2];
      xn1   <= xneg;
      yn1   <= yneg;
      last1 <= (cnt == ihse_pkg::LAST_NODE);
      xf1   <= xneg ? ihse_pkg::ONE_Q - xe : ihse_pkg::ONE_Q + xe;
      yf1   <= yneg ? ihse_pkg::ONE_Q - ye : ihse_pkg::ONE_Q + ye;
      z1    <= ze;
      zm1   <= ze - ihse_pkg::ONE_Q;
      pole1 <= (ze == ihse_pkg::ONE_Q);
    end
  end

  // stage 2: squares
  logic v2, up2, xn2, yn2, pole2, last2;
  logic [KW-1:0] k2;
  logic signed [CW-1:0] xf2, yf2, z2, zm2;
  logic signed [SW-1:0] xy2, zz2, zsq2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k2 <= k1; up2 <= up1; xn2 <= xn1; yn2 <= yn1; pole2 <= pole1; last2 <= last1;
      xf2 <= xf1; yf2 <= yf1; z2 <= z1; zm2 <= zm1;
      xy2  <= xf1 * yf1;
      zz2  <= z1 * z1;
      zsq2 <= zm1 * zm1;
    end
  end

  // stage 3: zeta factors and signed cross terms
  logic v3, up3, pole3, last3;
  logic [KW-1:0] k3;
  logic signed [CW-1:0] sx3, ty3, zf3, c43, zm3;
  logic signed [SW-1:0] xy3, zq3, zsq3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k3 <= k2; up3 <= up2; pole3 <= pole2; last3 <= last2;
      xy3  <= xy2;
      zsq3 <= zsq2;
      zm3  <= zm2;
      zq3  <= up2 ? zz2 - (SW'(z2) <<< ihse_pkg::FB) : ihse_pkg::ONE_SQ - zz2;
      sx3  <= xn2 ? -yf2 : yf2;
      ty3  <= yn2 ? -xf2 : xf2;
      zf3  <= up2 ? z2 : -(z2 + ihse_pkg::ONE_Q);
      c43  <= up2 ? (z2 <<< 1) - ihse_pkg::ONE_Q : -z2;
    end
  end

  // stage 4: products
  logic v4, up4, pole4, last4, zneg4;
  logic [KW-1:0] k4;
  logic signed [MW-1:0] p1;
  logic signed [DW-1:0] p2, p3, p4;
  logic signed [SW-1:0] p5, p6, p7;
  logic [EW-1:0] den_xy4, den_z4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k4 <= k3; up4 <= up3; pole4 <= pole3; last4 <= last3;
      zneg4   <= zm3[CW-1];
      p1      <= xy3 * zq3;
      p2      <= sx3 * zq3;
      p3      <= ty3 * zq3;
      p4      <= xy3 * c43;
      p5      <= sx3 * zf3;
      p6      <= ty3 * zf3;
      p7      <= up3 ? -xy3 : xy3;
      den_xy4 <= (zm3[CW-1] ? EW'(-zm3) : EW'(zm3))
                 << (up3 ? ihse_pkg::FB + 1 : ihse_pkg::FB + 2);
      den_z4  <= EW'(zsq3) << 1;
    end
  end

  // stage 5: magnitudes and divider operands
  logic v5, up5, pole5, last5;
  logic [KW-1:0] k5;
  logic [MW-1:0] m1, m2, m3, m4;
  logic n1, n2, n3, n4, n5, n6, n7;
  logic [NW-1:0] num5, num6, num7;
  logic [EW-1:0] den_xy5, den_z5;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (adv) v5 <= v4;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k5 <= k4; up5 <= up4; pole5 <= pole4; last5 <= last4;
      m1 <= p1[MW-1] ? MW'(-p1) : MW'(p1);
      m2 <= p2[DW-1] ? MW'(-p2) : MW'(p2);
      m3 <= p3[DW-1] ? MW'(-p3) : MW'(p3);
      m4 <= p4[DW-1] ? MW'(-p4) : MW'(p4);
      n1 <= p1[MW-1];
      n2 <= p2[DW-1];
      n3 <= p3[DW-1];
      n4 <= p4[DW-1];
      n5 <= p5[SW-1] ^ zneg4;
      n6 <= p6[SW-1] ^ zneg4;
      n7 <= p7[SW-1];
      num5 <= (p5[SW-1] ? NW'(-p5) : NW'(p5)) << ihse_pkg::OB;
      num6 <= (p6[SW-1] ? NW'(-p6) : NW'(p6)) << ihse_pkg::OB;
      num7 <= (p7[SW-1] ? NW'(-p7) : NW'(p7)) << ihse_pkg::OB;
      den_xy5 <= den_xy4;
      den_z5  <= den_z4;
    end
  end

  // mapping terms
  logic [NW-1:0] q_xi, q_eta, q_zeta;
  logic up_xi, up_eta, up_zeta;

  ihse_div #(.NUM_W(NW), .DEN_W(EW)) u_div_xi (
    .clk(clk), .en(adv), .num(num5), .den(den_xy5), .quot(q_xi), .round_up(up_xi)
  );
  ihse_div #(.NUM_W(NW), .DEN_W(EW)) u_div_eta (
    .clk(clk), .en(adv), .num(num6), .den(den_xy5), .quot(q_eta), .round_up(up_eta)
  );
  ihse_div #(.NUM_W(NW), .DEN_W(EW)) u_div_zeta (
    .clk(clk), .en(adv), .num(num7), .den(den_z5), .quot(q_zeta), .round_up(up_zeta)
  );

  // shape terms, rounded, then held alongside the divider
  ihse_pkg::mid_t mid6;
  ihse_pkg::mid_t dly [NW];
  logic [NW-1:0]  vd;

  always_comb begin
    mid6.node     = k5;
    mid6.pole     = pole5;
    mid6.last     = last5;
    mid6.neg_xi   = n5;
    mid6.neg_eta  = n6;
    mid6.neg_zeta = n7;
    if (up5) begin
      mid6.val   = ihse_pkg::sat32(ihse_pkg::rnd_shift(m1, ihse_pkg::SH_VAL_U), n1);
      mid6.dxi   = ihse_pkg::sat32(ihse_pkg::rnd_shift(m2, ihse_pkg::SH_DER_U), n2);
      mid6.deta  = ihse_pkg::sat32(ihse_pkg::rnd_shift(m3, ihse_pkg::SH_DER_U), n3);
      mid6.dzeta = ihse_pkg::sat32(ihse_pkg::rnd_shift(m4, ihse_pkg::SH_DZ_U), n4);
    end else begin
      mid6.val   = ihse_pkg::sat32(ihse_pkg::rnd_shift(m1, ihse_pkg::SH_VAL_L), n1);
      mid6.dxi   = ihse_pkg::sat32(ihse_pkg::rnd_shift(m2, ihse_pkg::SH_DER_L), n2);
      mid6.deta  = ihse_pkg::sat32(ihse_pkg::rnd_shift(m3, ihse_pkg::SH_DER_L), n3);
      mid6.dzeta = ihse_pkg::sat32(ihse_pkg::rnd_shift(m4, ihse_pkg::SH_DZ_L), n4);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vd <= '0;
    else if (adv) vd <= {vd[NW-2:0], v5};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dly[0] <= mid6;
      for (int i = 1; i < NW; i++) dly[i] <= dly[i-1];
    end
  end

  // output register
  ihse_pkg::mid_t tail;
  assign tail = dly[NW-1];

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= vd[NW-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.node_index   <= tail.node;
      out_data.shape_value  <= tail.val;
      out_data.shape_d_xi   <= tail.dxi;
      out_data.shape_d_eta  <= tail.deta;
      out_data.shape_d_zeta <= tail.dzeta;
      out_data.pole_flag    <= tail.pole;
      out_data.last_node    <= tail.last;
      if (tail.pole) begin
        out_data.map_d_xi   <= '0;
        out_data.map_d_eta  <= '0;
        out_data.map_d_zeta <= '0;
      end else begin
        out_data.map_d_xi   <= ihse_pkg::sat32(64'(q_xi) + 64'(up_xi), tail.neg_xi);
        out_data.map_d_eta  <= ihse_pkg::sat32(64'(q_eta) + 64'(up_eta), tail.neg_eta);
        out_data.map_d_zeta <= ihse_pkg::sat32(64'(q_zeta) + 64'(up_zeta), tail.neg_zeta);
      end
    end
  end

endmodule

FILE: dv/tb_infinite_hex_shape_eval.sv
// Testbench for infinite_hex_shape_eval: drives coordinate words and checks eight node words
// per coordinate against an in-bench fixed-point predictor. Depends on ihse_pkg and the RTL.
`timescale 1ns / 100ps
module tb_infinite_hex_shape_eval;

  localparam int CYCLE_LIMIT = 300000;
  localparam int NODE_CNT = 8;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  ihse_pkg::in_word_t  in_data;
  logic                out_valid;
  logic                out_stall;
  ihse_pkg::out_word_t out_data;

  ihse_pkg::out_word_t node_expect_q[$];
  int        err_cnt = 0;
  int        cycle_cnt = 0;
  bit        idle_on = 1'b1;
  int        hold_off = 0;

  infinite_hex_shape_eval uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // apply sign to a magnitude and clamp to 32-bit signed
  function automatic logic [31:0] clamp32(logic [127:0] mag, bit neg);
    if (mag > 128'h8000_0000) return neg ? 32'h8000_0000 : 32'h7fff_ffff;
    if (neg) return ~mag[31:0] + 32'd1;
    if (mag[31]) return 32'h7fff_ffff;
    return mag[31:0];
  endfunction

  // round v * 2^-sh to nearest, ties away from zero
  function automatic logic [31:0] round_shift_q(logic signed [127:0] v, int sh);
    logic [127:0] m;
    logic [127:0] r;
    m = (v < 0) ? -v : v;
    r = (m >> sh) + m[sh-1];
    return clamp32(r, v < 0);
  endfunction

  // round (num * 2^OB) / den to nearest, ties away from zero
  function automatic logic [31:0] round_div_q(logic signed [127:0] num,
                                              logic signed [127:0] den);
    logic [127:0] n;
    logic [127:0] d;
    logic [127:0] q;
    logic [127:0] r;
    bit neg;
    neg = (num < 0) != (den < 0);
    n = ((num < 0) ? -num : num) << ihse_pkg::OB;
    d = (den < 0) ? -den : den;
    q = n / d;
    r = n % d;
    if (r >= d - r) q = q + 1;
    return clamp32(q, neg);
  endfunction

  function automatic ihse_pkg::out_word_t node_result(ihse_pkg::in_word_t w, int k);
    logic signed [127:0] x, y, z, one, sx, sy, xf, yf, xy, zq, zm, zfac, den;
    ihse_pkg::out_word_t o;
    bit upper;
    x = w.coord_xi;
    y = w.coord_eta;
    z = w.coord_zeta;
    one = 128'sd1 <<< ihse_pkg::FB;
    sx = (k == 0 || k == 3 || k == 4 || k == 7) ? -1 : 1;
    sy = (k == 0 || k == 1 || k == 4 || k == 5) ? -1 : 1;
    upper = k < 4;
    xf = one + sx * x;
    yf = one + sy * y;
    xy = xf * yf;
    zq = upper ? (z * z - z * one) : (one * one - z * z);
    zm = z - one;
    o.node_index = k[ihse_pkg::NODE_W-1:0];
    o.shape_value = round_shift_q(xy * zq, upper ? ihse_pkg::SH_VAL_U : ihse_pkg::SH_VAL_L);
    o.shape_d_xi  = round_shift_q(sx * yf * zq,
                                  upper ? ihse_pkg::SH_DER_U : ihse_pkg::SH_DER_L);
    o.shape_d_eta = round_shift_q(sy * xf * zq,
                                  upper ? ihse_pkg::SH_DER_U : ihse_pkg::SH_DER_L);
    if (upper) o.shape_d_zeta = round_shift_q(xy * (2 * z - one), ihse_pkg::SH_DZ_U);
    else o.shape_d_zeta = round_shift_q(-(xy * z), ihse_pkg::SH_DZ_L);
    o.pole_flag = (zm == 0);
    if (o.pole_flag) begin
      o.map_d_xi = '0;
      o.map_d_eta = '0;
      o.map_d_zeta = '0;
    end else begin
      zfac = upper ? z : -(z + one);
      den = zm <<< (ihse_pkg::FB + (upper ? 1 : 2));
      o.map_d_xi   = round_div_q(sx * yf * zfac, den);
      o.map_d_eta  = round_div_q(sy * xf * zfac, den);
      o.map_d_zeta = round_div_q(upper ? -xy : xy, 2 * zm * zm);
    end
    o.last_node = (k == NODE_CNT - 1);
    return o;
  endfunction

  // offer one word, hold until taken, then queue its eight node words
  task automatic send_coord(logic signed [15:0] xi, logic signed [15:0] eta,
                            logic signed [15:0] zeta);
    int gap;
    ihse_pkg::in_word_t w;
    w.coord_xi = xi;
    w.coord_eta = eta;
    w.coord_zeta = zeta;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    for (int k = 0; k < NODE_CNT; k++) node_expect_q.push_back(node_result(w, k));
    @(negedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $error("%s: expected %h, got %h", name, e, a);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    ihse_pkg::out_word_t e;
    if (!rst && out_valid && !out_stall) begin
      if (node_expect_q.size() == 0) begin
        $error("unexpected node word %p", out_data);
        err_cnt++;
      end else begin
        e = node_expect_q.pop_front();
        check_field("node_index", 32'(e.node_index), 32'(out_data.node_index));
        check_field("shape_value", e.shape_value, out_data.shape_value);
        check_field("shape_d_xi", e.shape_d_xi, out_data.shape_d_xi);
        check_field("shape_d_eta", e.shape_d_eta, out_data.shape_d_eta);
        check_field("shape_d_zeta", e.shape_d_zeta, out_data.shape_d_zeta);
        check_field("map_d_xi", e.map_d_xi, out_data.map_d_xi);
        check_field("map_d_eta", e.map_d_eta, out_data.map_d_eta);
        check_field("map_d_zeta", e.map_d_zeta, out_data.map_d_zeta);
        check_field("pole_flag", 32'(e.pole_flag), 32'(out_data.pole_flag));
        check_field("last_node", 32'(e.last_node), 32'(out_data.last_node));
      end
    end
  end

  // receiver stall: long hold-off when requested, else random bursts
  initial begin
    int burst;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_stall <= 1'b1;
        hold_off--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 13);
        out_stall <= 1'b1;
        repeat (burst - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic test_directed();
    send_coord(-16384, -16384, -16384);
    send_coord(16384, 16384, -16384);
    send_coord(0, 0, 0);
    send_coord(16384, -16384, 16384);   // pole
    send_coord(-16384, 16384, 16384);   // pole
    send_coord(0, 0, 16383);            // just below the pole
    send_coord(0, 0, 16385);            // just above the pole
    send_coord(16384, 16384, 16383);
    send_coord(-32768, -32768, -32768);
    send_coord(32767, 32767, 32767);
    send_coord(-32768, 32767, 0);
    send_coord(32767, -32768, 16384);
    send_coord(8192, -8192, 8192);
    send_coord(-1, 1, -1);
    send_coord(16384, 16384, 0);
  endtask

  function automatic logic signed [15:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return 16'sd16384;
      2: return -16'sd16384;
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_coord(pick_coord(), pick_coord(), pick_coord());
  endtask

  // hold the output long enough that the pipeline fills and stalls its input
  task automatic test_backpressure();
    hold_off = 400;
    test_random(12);
  endtask

  initial begin
    int waited;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random(33);
    test_backpressure();
    test_random(30);
    idle_on = 1'b0;
    test_random(20);
    in_valid <= 1'b0;
    waited = 0;
    while (node_expect_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (80) @(posedge clk);
    if (err_cnt == 0 && node_expect_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
